>>> rtl/hkrb_pkg.sv
// hkrb_pkg: shared types and constants for the HID keyboard report builder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package hkrb_pkg;

	localparam int KEY_SLOTS = 6;
	localparam int CODE_W    = 8;

	localparam logic [CODE_W-1:0] MOD_FIRST = 8'hE0;
	localparam logic [CODE_W-1:0] MOD_LAST  = 8'hE7;

	typedef logic [CODE_W-1:0] code_t;

	typedef enum logic [1:0] {
		FUNC_PRESS   = 2'd0,
		FUNC_RELEASE = 2'd1,
		FUNC_POLL    = 2'd2
	} func_t;

	// per-cycle command broadcast to every slot cell
	typedef struct packed {
		logic  append;
		logic  remove;
		code_t code;
	} cell_ctrl_t;

	function automatic logic is_modifier(input code_t code);
		is_modifier = code inside {[MOD_FIRST:MOD_LAST]};
	endfunction

endpackage

>>> rtl/hkrb_cell.sv
// hkrb_cell: one key slot of the report; holds a usage code and an occupied flag.
// Depends on hkrb_pkg. Cells are chained; a release shifts later slots down.
`timescale 1ns / 1ps

module hkrb_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  hkrb_pkg::cell_ctrl_t ctrl,
	input  logic                prev_occ,
	input  logic                prev_hit,
	input  logic                next_occ,
	input  hkrb_pkg::code_t     next_code,
	output logic                occ,
	output hkrb_pkg::code_t     code,
	output logic                hit
);
	import hkrb_pkg::*;

	logic  occ_q;
	code_t code_q;
	logic  own_match;

	assign own_match = occ_q && (code_q == ctrl.code);
	assign hit       = prev_hit || own_match;
	assign occ       = occ_q;
	assign code      = code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q  <= 1'b0;
			code_q <= '0;
		end else if (ctrl.remove && hit) begin
			occ_q  <= next_occ;
			code_q <= next_code;
		end else if (ctrl.append && prev_occ && !occ_q) begin
			occ_q  <= 1'b1;
			code_q <= ctrl.code;
		end
	end

endmodule

>>> rtl/hid_keyboard_report_builder.sv
// hid_keyboard_report_builder: top level, modifier byte, change flag and report register.
// Depends on hkrb_pkg and hkrb_cell (a chain of KEY_SLOTS slot cells).
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid/in_ready, func, keycode): one beat per key event.
//   func press or release updates the held-key state and gives no result;
//   func poll gives one beat on the output channel (out_valid/out_ready) with
//   sent, modifiers and the six slot codes in press order, then clears the
//   change flag. func 3 is dropped.
//   Every event completes in the cycle it is accepted: one beat per cycle if in_ready.
//   A poll result appears in the cycle after acceptance, from the report register.
//   The state update is a single pass through the slot chain: compare every
//   slot against the keycode, then append at the first free slot or shift the
//   later slots down by one.
//   While a result waits, in_ready follows out_ready; when the output register
//   is empty, in_ready is high.
//   Reset clears the modifiers, all slots, the change flag and out_valid.
module hid_keyboard_report_builder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          func,
	input  hkrb_pkg::code_t     keycode,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                sent,
	output hkrb_pkg::code_t     modifiers,
	output hkrb_pkg::code_t     slot_zero,
	output hkrb_pkg::code_t     slot_one,
	output hkrb_pkg::code_t     slot_two,
	output hkrb_pkg::code_t     slot_three,
	output hkrb_pkg::code_t     slot_four,
	output hkrb_pkg::code_t     slot_five
);
	import hkrb_pkg::*;

	logic       accept;
	cell_ctrl_t ctrl;
	logic [KEY_SLOTS-1:0] occ;
	logic [KEY_SLOTS-1:0] hit;
	code_t      slot_code [KEY_SLOTS];
	logic       any_hit;
	logic       full;
	logic       is_mod;
	logic [2:0] mod_bit;
	logic       mod_set;

	code_t mod_q, mod_d;
	logic  changed_q;
	logic  chg;
	logic  poll;
	logic  out_valid_q;
	logic  sent_q;
	code_t modifiers_q;
	code_t slot_q [KEY_SLOTS];

	assign accept  = in_valid && in_ready;
	assign in_ready = !out_valid_q || out_ready;
	assign any_hit = hit[KEY_SLOTS-1];
	assign full    = occ[KEY_SLOTS-1];
	assign is_mod  = is_modifier(keycode);
	assign mod_bit = keycode[2:0];
	assign mod_set = mod_q[mod_bit];

	always_comb begin
		ctrl.append = 1'b0;
		ctrl.remove = 1'b0;
		ctrl.code   = keycode;
		mod_d       = mod_q;
		chg         = 1'b0;
		poll        = 1'b0;
		if (accept) begin
			case (func)
				FUNC_PRESS: begin
					if (is_mod) begin
						if (!mod_set) begin
							mod_d[mod_bit] = 1'b1;
							chg            = 1'b1;
						end
					end else if (!any_hit && !full) begin
						ctrl.append = 1'b1;
						chg         = 1'b1;
					end
				end
				FUNC_RELEASE: begin
					if (is_mod) begin
						if (mod_set) begin
							mod_d[mod_bit] = 1'b0;
							chg            = 1'b1;
						end
					end else if (any_hit) begin
						ctrl.remove = 1'b1;
						chg         = 1'b1;
					end
				end
				FUNC_POLL: poll = 1'b1;
				default: ;
			endcase
		end
	end

	genvar i;
	generate
		for (i = 0; i < KEY_SLOTS; i++) begin : g_cell
			logic  p_occ, p_hit, n_occ;
			code_t n_code;
			if (i == 0) begin : g_first
				assign p_occ = 1'b1;
				assign p_hit = 1'b0;
			end else begin : g_mid
				assign p_occ = occ[i-1];
				assign p_hit = hit[i-1];
			end
			if (i == KEY_SLOTS-1) begin : g_last
				assign n_occ  = 1'b0;
				assign n_code = '0;
			end else begin : g_next
				assign n_occ  = occ[i+1];
				assign n_code = slot_code[i+1];
			end
			hkrb_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctrl      (ctrl),
				.prev_occ  (p_occ),
				.prev_hit  (p_hit),
				.next_occ  (n_occ),
				.next_code (n_code),
				.occ       (occ[i]),
				.code      (slot_code[i]),
				.hit       (hit[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q       <= '0;
			changed_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			mod_q <= mod_d;
			if (poll)
				changed_q <= 1'b0;
			else if (chg)
				changed_q <= 1'b1;
			if (poll)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// report register, loaded on a poll
	always_ff @(posedge clk) begin
		if (poll) begin
			sent_q      <= changed_q;
			modifiers_q <= mod_q;
			slot_q      <= slot_code;
		end
	end

	assign out_valid  = out_valid_q;
	assign sent       = sent_q;
	assign modifiers  = modifiers_q;
	assign slot_zero  = slot_q[0];
	assign slot_one   = slot_q[1];
	assign slot_two   = slot_q[2];
	assign slot_three = slot_q[3];
	assign slot_four  = slot_q[4];
	assign slot_five  = slot_q[5];

endmodule

>>> rtl/hkrb_checker.sv
// hkrb_checker: port-level assertions for hid_keyboard_report_builder.
// Depends on hkrb_pkg; attached to the top level by the bind below.
`timescale 1ns / 1ps

module hkrb_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_ready,
	input logic [1:0]      func,
	input hkrb_pkg::code_t keycode,
	input logic            out_valid,
	input logic            out_ready,
	input logic            sent,
	input hkrb_pkg::code_t modifiers,
	input hkrb_pkg::code_t slot_zero
);
	import hkrb_pkg::*;

	logic poll_beat;
	assign poll_beat = in_valid && in_ready && (func == FUNC_POLL);

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(modifiers) && $stable(slot_zero))
		else $error("result beat changed while stalled");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty report register");

	a_poll_result: assert property (@(posedge clk) disable iff (!arst_n)
		poll_beat |=> out_valid)
		else $error("poll gave no result beat");

	a_second_poll_unchanged: assert property (@(posedge clk) disable iff (!arst_n)
		poll_beat ##1 poll_beat |=> !sent)
		else $error("back-to-back poll reported a change");

	a_modifier_press: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && func == FUNC_PRESS && keycode == MOD_FIRST) ##1 poll_beat
		|=> modifiers[0])
		else $error("modifier press missing from report");

endmodule

bind hid_keyboard_report_builder hkrb_checker u_hkrb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.func      (func),
	.keycode   (keycode),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.sent      (sent),
	.modifiers (modifiers),
	.slot_zero (slot_zero)
);

>>> verif/testbench.sv
// testbench: self-checking bench for hid_keyboard_report_builder.
// Directed table, then random key events against a predictor; depends on hkrb_pkg.
`timescale 1ns / 1ps

module testbench;
	import hkrb_pkg::*;

	localparam logic [1:0] FUNC_SPARE = 2'd3;
	localparam int RANDOM_EVENTS = 1700;

	typedef struct packed {
		logic                        sent;
		code_t                       modifiers;
		code_t [KEY_SLOTS-1:0]       keys;
	} report_t;

	typedef struct {
		logic [1:0] op;
		code_t      code;
		bit         typed;
		report_t    want;
	} step_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [1:0] func = FUNC_PRESS;
	code_t      keycode = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       sent;
	code_t      modifiers;
	code_t      slot_zero, slot_one, slot_two, slot_three, slot_four, slot_five;

	// predictor state
	code_t                 held_mods;
	code_t [KEY_SLOTS-1:0] held_keys;
	int unsigned           held_count;
	bit                    key_down [256];
	bit                    report_dirty;

	report_t     report_q [$];
	int unsigned mismatches = 0;
	bit          no_idle = 1'b0;

	hid_keyboard_report_builder uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.keycode    (keycode),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sent       (sent),
		.modifiers  (modifiers),
		.slot_zero  (slot_zero),
		.slot_one   (slot_one),
		.slot_two   (slot_two),
		.slot_three (slot_three),
		.slot_four  (slot_four),
		.slot_five  (slot_five)
	);

	always #6 clk = ~clk;

	function automatic report_t mk_report(input logic s, input code_t m, input code_t k0,
			input code_t k1, input code_t k2, input code_t k3, input code_t k4, input code_t k5);
		report_t r;
		r.sent = s;
		r.modifiers = m;
		r.keys = {k5, k4, k3, k2, k1, k0};
		return r;
	endfunction

	function automatic int unsigned idle_len();
		int unsigned r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic void track_key_event(input logic [1:0] op, input code_t code,
			output bit polled, output report_t rep);
		bit is_mod;
		bit found;
		is_mod = (code >= MOD_FIRST) && (code <= MOD_LAST);
		found = 1'b0;
		polled = 1'b0;
		rep = '0;
		case (op)
			FUNC_PRESS: begin
				if (!key_down[code]) begin
					if (is_mod) begin
						held_mods[code[2:0]] = 1'b1;
						key_down[code] = 1'b1;
						report_dirty = 1'b1;
					end else if (held_count < KEY_SLOTS) begin
						held_keys[held_count] = code;
						held_count++;
						key_down[code] = 1'b1;
						report_dirty = 1'b1;
					end
				end
			end
			FUNC_RELEASE: begin
				if (key_down[code]) begin
					if (is_mod) begin
						held_mods[code[2:0]] = 1'b0;
						key_down[code] = 1'b0;
						report_dirty = 1'b1;
					end else begin
						for (int i = 0; i < KEY_SLOTS; i++) begin
							if (!found && i < held_count && held_keys[i] == code)
								found = 1'b1;
							if (found && i + 1 < KEY_SLOTS)
								held_keys[i] = held_keys[i + 1];
						end
						if (found) begin
							held_count--;
							held_keys[held_count] = '0;
							key_down[code] = 1'b0;
							report_dirty = 1'b1;
						end
					end
				end
			end
			FUNC_POLL: begin
				polled = 1'b1;
				rep.sent = report_dirty;
				rep.modifiers = held_mods;
				rep.keys = held_keys;
				report_dirty = 1'b0;
			end
			default: ;
		endcase
	endfunction

	task automatic offer_event(input logic [1:0] op, input code_t code, output bit polled,
			output report_t rep);
		int unsigned gap;
		gap = idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= op;
		keycode <= code;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		track_key_event(op, code, polled, rep);
	endtask

	task automatic pick_random_event(output logic [1:0] op, output code_t code);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 38)
			op = FUNC_PRESS;
		else if (r < 70)
			op = FUNC_RELEASE;
		else if (r < 92)
			op = FUNC_POLL;
		else
			op = FUNC_SPARE;
		r = $urandom_range(0, 99);
		if (op == FUNC_RELEASE && r < 55 && (held_count > 0 || held_mods != '0)) begin
			if (held_count > 0 && ($urandom_range(0, 1) == 1 || held_mods == '0))
				code = held_keys[$urandom_range(0, held_count - 1)];
			else
				code = {5'b11100, 3'($urandom_range(0, 7))};
		end else if (r < 75) begin
			if ($urandom_range(0, 3) == 0)
				code = {5'b11100, 3'($urandom_range(0, 7))};
			else
				code = 8'($urandom_range(0, 11));
		end else begin
			code = 8'($urandom);
		end
	endtask

	task automatic note_mismatch(input string what, input report_t want, input report_t seen);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s: expected sent=%0d mods=%02h keys(5..0)=%h, got sent=%0d mods=%02h keys(5..0)=%h",
				$realtime, what, want.sent, want.modifiers, want.keys,
				seen.sent, seen.modifiers, seen.keys);
	endtask

	// result beats
	always @(posedge clk) begin : watch_reports
		report_t seen;
		report_t want;
		if (arst_n && out_valid && out_ready) begin
			seen.sent = sent;
			seen.modifiers = modifiers;
			seen.keys = {slot_five, slot_four, slot_three, slot_two, slot_one, slot_zero};
			if (report_q.size() == 0) begin
				note_mismatch("unexpected report", '0, seen);
			end else begin
				want = report_q.pop_front();
				if (want.sent !== seen.sent || want.modifiers !== seen.modifiers
						|| want.keys !== seen.keys)
					note_mismatch("report wrong", want, seen);
			end
		end
	end

	// receiver back-pressure
	initial begin : host_side
		int unsigned stall;
		@(posedge arst_n);
		forever begin
			stall = idle_len();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
		end
	end

	initial begin : key_source
		step_t       plan [$];
		logic [1:0]  op;
		code_t       code;
		bit          polled;
		report_t     rep;
		held_mods = '0;
		held_keys = '0;
		held_count = 0;
		report_dirty = 1'b0;
		foreach (key_down[i])
			key_down[i] = 1'b0;
		plan = '{
			'{FUNC_POLL,    8'h00, 1'b1, mk_report(1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00)},
			'{FUNC_PRESS,   8'hE0, 1'b0, '0},
			'{FUNC_PRESS,   8'hE7, 1'b0, '0},
			'{FUNC_POLL,    8'h00, 1'b1, mk_report(1'b1, 8'h81, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00)},
			'{FUNC_PRESS,   8'h00, 1'b0, '0},
			'{FUNC_PRESS,   8'hFF, 1'b0, '0},
			'{FUNC_PRESS,   8'h04, 1'b0, '0},
			'{FUNC_PRESS,   8'h04, 1'b0, '0},
			'{FUNC_PRESS,   8'h05, 1'b0, '0},
			'{FUNC_PRESS,   8'h06, 1'b0, '0},
			'{FUNC_PRESS,   8'h07, 1'b0, '0},
			'{FUNC_PRESS,   8'h08, 1'b0, '0},
			'{FUNC_POLL,    8'hAA, 1'b1, mk_report(1'b1, 8'h81, 8'h00, 8'hFF, 8'h04, 8'h05, 8'h06, 8'h07)},
			'{FUNC_RELEASE, 8'h08, 1'b0, '0},
			'{FUNC_RELEASE, 8'hE5, 1'b0, '0},
			'{FUNC_POLL,    8'h55, 1'b1, mk_report(1'b0, 8'h81, 8'h00, 8'hFF, 8'h04, 8'h05, 8'h06, 8'h07)},
			'{FUNC_RELEASE, 8'hFF, 1'b0, '0},
			'{FUNC_RELEASE, 8'hFF, 1'b0, '0},
			'{FUNC_SPARE,   8'h55, 1'b0, '0},
			'{FUNC_RELEASE, 8'hE0, 1'b0, '0},
			'{FUNC_PRESS,   8'h08, 1'b0, '0},
			'{FUNC_POLL,    8'h00, 1'b0, '0},
			'{FUNC_RELEASE, 8'h00, 1'b0, '0},
			'{FUNC_RELEASE, 8'hE7, 1'b0, '0},
			'{FUNC_POLL,    8'hFF, 1'b0, '0}
		};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			offer_event(plan[i].op, plan[i].code, polled, rep);
			if (polled)
				report_q.push_back(plan[i].typed ? plan[i].want : rep);
		end

		for (int i = 0; i < RANDOM_EVENTS; i++) begin
			// a burst with no gaps on either side every few hundred beats
			no_idle = (i % 300) >= 240;
			pick_random_event(op, code);
			offer_event(op, code, polled, rep);
			if (polled)
				report_q.push_back(rep);
		end
		no_idle = 1'b0;
		in_valid <= 1'b0;

		while (report_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin : watchdog
		#20_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
